// ----- design/laser_point_sparkle_inserter_assert.svh -----
// ---------------------------------------------------------------------------
// laser point sparkle inserter assertion macros
// shared property templates, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef LASER_POINT_SPARKLE_INSERTER_ASSERT_SVH
`define LASER_POINT_SPARKLE_INSERTER_ASSERT_SVH

// same-cycle implication
`define LPSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lpsi_pkg.sv -----
// ---------------------------------------------------------------------------
// lpsi_pkg
// types and constants shared by the sparkle inserter modules
// ---------------------------------------------------------------------------
package lpsi_pkg;

  localparam int unsigned LANES = 3;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam logic [15:0] HALF_Q16      = 16'h8000;
  localparam logic [15:0] BIAS_MSB      = 16'h8000;
  localparam logic [15:0] COLOR_MAX     = 16'hFFFF;
  localparam logic [7:0]  FADE_REPEATS  = 8'd2;
  localparam logic [7:0]  SPARK_REPEATS = 8'd5;

  typedef enum logic [2:0] {
    CFG_ENABLE,
    CFG_DENSITY,
    CFG_SPK_RED,
    CFG_SPK_GREEN,
    CFG_SPK_BLUE,
    CFG_SPK_ALPHA,
    CFG_FOLLOW,
    CFG_MIN_DIST
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEL_POS,
    SEL_BLEND,
    SEL_FADE
  } lerp_sel_t;

  typedef enum logic [1:0] {
    EMIT_FADE,
    EMIT_SPARK,
    EMIT_CUR
  } emit_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_SQ,
    ST_DEC,
    ST_FADE,
    ST_FST,
    ST_E_FADE0,
    ST_E_SPARK,
    ST_E_FADE1,
    ST_E_CUR
  } state_t;

  typedef struct packed {
    logic       cap;
    lerp_sel_t  sel;
    logic       st_pos;
    logic       st_blend;
    logic       st_fade;
    logic       decide;
    logic       emit;
    emit_kind_t kind;
    logic       commit;
  } dp_cmd_t;

  typedef struct packed {
    logic sparkle;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] random_mix;
    logic [15:0] random_gate;
    logic [16:0] ratio;
    logic [7:0]  repeats;
    logic [15:0] color_b;
    logic [15:0] color_g;
    logic [15:0] color_r;
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_repeats;
    logic [15:0] out_b;
    logic [15:0] out_g;
    logic [15:0] out_r;
    logic [15:0] out_z;
    logic [15:0] out_y;
    logic [15:0] out_x;
  } out_item_t;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);
  localparam int unsigned CFG_W = 17;

endpackage

// ----- design/lpsi_lerp.sv -----
// ---------------------------------------------------------------------------
// lpsi_lerp
// one interpolation lane: round(a*(1-w) + b*w), w in Q1.16, products registered
// ---------------------------------------------------------------------------
module lpsi_lerp
  import lpsi_pkg::*;
(
  input  logic        clk,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  logic [16:0] w,
  output logic [15:0] y
);

  logic [32:0] pa_r;
  logic [32:0] pb_r;
  logic [33:0] sum;
  logic [17:0] q;

  always_ff @(posedge clk) begin
    pa_r <= 33'(a) * 33'(ONE_Q16 - w);
    pb_r <= 33'(b) * 33'(w);
  end

  assign sum = 34'(pa_r) + 34'(pb_r) + 34'(HALF_Q16);
  assign q   = sum[33:16];
  assign y   = (q > 18'(COLOR_MAX)) ? COLOR_MAX : q[15:0];

endmodule

// ----- design/lpsi_dp.sv -----
// ---------------------------------------------------------------------------
// lpsi_dp
// datapath: config registers, point state, decision math, lanes, output register
// ---------------------------------------------------------------------------
`include "laser_point_sparkle_inserter_assert.svh"

module lpsi_dp
  import lpsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic [0:0]       in_tuser,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  function automatic logic [16:0] sat_q16(input logic [16:0] v);
    sat_q16 = (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // configuration
  logic        enable_r;
  logic [16:0] density_r;
  logic [15:0] spk_cfg_r [LANES];
  logic [16:0] alpha_r;
  logic        follow_r;
  logic [15:0] min_dist_r;

  // captured point and kept state
  in_item_t    cur_r;
  logic        fs_r;
  logic [15:0] prev_pos_r [LANES];
  logic [15:0] prev_col_r [LANES];
  logic [15:0] spark_x_r;
  logic [15:0] spark_y_r;

  // decision math
  logic [16:0]        eff_d_r;
  logic [16:0]        eff_a_r;
  logic signed [16:0] dx_r;
  logic signed [16:0] dy_r;
  logic [31:0]        m2_r;
  logic [32:0]        dx2_r;
  logic [32:0]        dy2_r;
  logic               spk_r;

  // lane results
  logic [15:0] zpos_r [LANES];
  logic [15:0] sc_r   [LANES];
  logic [15:0] fade_r [LANES];

  // output register
  out_item_t   out_r;
  logic        out_last_r;
  logic        out_valid_r;

  logic [16:0]        ratio_s;
  logic [16:0]        dens_s;
  logic [16:0]        alpha_s;
  logic [33:0]        prod_d;
  logic [33:0]        prod_a;
  logic [15:0]        sx;
  logic [15:0]        sy;
  logic signed [16:0] dx_nxt;
  logic signed [16:0] dy_nxt;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic [33:0]        d2;
  logic               gate_ok;
  logic [15:0]        cur_pos [LANES];
  logic [15:0]        cur_col [LANES];
  logic [15:0]        lane_a  [LANES];
  logic [15:0]        lane_b  [LANES];
  logic [16:0]        lane_w  [LANES];
  logic [15:0]        lane_y  [LANES];
  logic [16:0]        mix_w;

  assign ratio_s = sat_q16(cur_r.ratio);
  assign dens_s  = sat_q16(density_r);
  assign alpha_s = sat_q16(alpha_r);
  assign prod_d  = 34'(ratio_s) * 34'(dens_s) + 34'(HALF_Q16);
  assign prod_a  = 34'(ratio_s) * 34'(alpha_s) + 34'(HALF_Q16);

  // frame start measures from the origin
  assign sx     = fs_r ? 16'h0000 : spark_x_r;
  assign sy     = fs_r ? 16'h0000 : spark_y_r;
  assign dx_nxt = $signed({cur_r.pos_x[15], cur_r.pos_x}) - $signed({sx[15], sx});
  assign dy_nxt = $signed({cur_r.pos_y[15], cur_r.pos_y}) - $signed({sy[15], sy});
  assign dx_sq  = dx_r * dx_r;
  assign dy_sq  = dy_r * dy_r;
  assign d2     = 34'(dx2_r) + 34'(dy2_r);

  assign gate_ok     = 17'(cur_r.random_gate) < eff_d_r;
  assign sts.sparkle = enable_r && !fs_r && gate_ok && (d2 > 34'(m2_r));
  assign sts.out_free = !out_valid_r || out_tready;

  assign cur_pos[0] = cur_r.pos_x;
  assign cur_pos[1] = cur_r.pos_y;
  assign cur_pos[2] = cur_r.pos_z;
  assign cur_col[0] = cur_r.color_r;
  assign cur_col[1] = cur_r.color_g;
  assign cur_col[2] = cur_r.color_b;
  assign mix_w      = {1'b0, cur_r.random_mix};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      case (cmd.sel)
        SEL_POS: begin
          lane_a[i] = prev_pos_r[i] ^ BIAS_MSB;
          lane_b[i] = cur_pos[i] ^ BIAS_MSB;
          lane_w[i] = mix_w;
        end
        SEL_BLEND: begin
          lane_a[i] = prev_col_r[i];
          lane_b[i] = spk_cfg_r[i];
          lane_w[i] = eff_a_r;
        end
        SEL_FADE: begin
          lane_a[i] = prev_col_r[i];
          lane_b[i] = sc_r[i];
          lane_w[i] = mix_w;
        end
        default: begin
          lane_a[i] = '0;
          lane_b[i] = '0;
          lane_w[i] = '0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lpsi_lerp u_lerp (
      .clk (clk),
      .a   (lane_a[i]),
      .b   (lane_b[i]),
      .w   (lane_w[i]),
      .y   (lane_y[i])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      density_r  <= '0;
      for (int i = 0; i < LANES; i++) spk_cfg_r[i] <= COLOR_MAX;
      alpha_r    <= ONE_Q16;
      follow_r   <= 1'b0;
      min_dist_r <= 16'd33;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ENABLE:    enable_r     <= cfg_wdata[0];
        CFG_DENSITY:   density_r    <= cfg_wdata[16:0];
        CFG_SPK_RED:   spk_cfg_r[0] <= cfg_wdata[15:0];
        CFG_SPK_GREEN: spk_cfg_r[1] <= cfg_wdata[15:0];
        CFG_SPK_BLUE:  spk_cfg_r[2] <= cfg_wdata[15:0];
        CFG_SPK_ALPHA: alpha_r      <= cfg_wdata[16:0];
        CFG_FOLLOW:    follow_r     <= cfg_wdata[0];
        CFG_MIN_DIST:  min_dist_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // point state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        prev_pos_r[i] <= '0;
        prev_col_r[i] <= '0;
      end
      spark_x_r <= '0;
      spark_y_r <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < LANES; i++) begin
        prev_pos_r[i] <= cur_pos[i];
        prev_col_r[i] <= cur_col[i];
      end
      if (spk_r) begin
        spark_x_r <= prev_pos_r[0];
        spark_y_r <= prev_pos_r[1];
      end else if (fs_r) begin
        spark_x_r <= '0;
        spark_y_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur_r <= in_item_t'(in_tdata);
      fs_r  <= in_tuser[0];
    end
    eff_d_r <= follow_r ? prod_d[32:16] : dens_s;
    eff_a_r <= follow_r ? prod_a[32:16] : alpha_s;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    m2_r    <= 32'(min_dist_r) * 32'(min_dist_r);
    dx2_r   <= dx_sq[32:0];
    dy2_r   <= dy_sq[32:0];
    if (cmd.decide) spk_r <= sts.sparkle;
    for (int i = 0; i < LANES; i++) begin
      if (cmd.st_pos)   zpos_r[i] <= lane_y[i] ^ BIAS_MSB;
      if (cmd.st_blend) sc_r[i]   <= lane_y[i];
      if (cmd.st_fade)  fade_r[i] <= lane_y[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        EMIT_FADE: begin
          out_r      <= {FADE_REPEATS, fade_r[2], fade_r[1], fade_r[0],
                         zpos_r[2], zpos_r[1], zpos_r[0]};
          out_last_r <= 1'b0;
        end
        EMIT_SPARK: begin
          out_r      <= {SPARK_REPEATS, sc_r[2], sc_r[1], sc_r[0],
                         zpos_r[2], zpos_r[1], zpos_r[0]};
          out_last_r <= 1'b0;
        end
        default: begin
          out_r      <= {cur_r.repeats, cur_r.color_b, cur_r.color_g, cur_r.color_r,
                         cur_r.pos_z, cur_r.pos_y, cur_r.pos_x};
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tlast  = out_last_r;

  `LPSI_ASSERT_NOW(a_emit_free, cmd.emit, sts.out_free, "emit into a full output register")
  `LPSI_ASSERT_NOW(a_commit_cur, cmd.commit, cmd.emit && cmd.kind == EMIT_CUR, "commit without current point")

endmodule

// ----- design/lpsi_ctrl.sv -----
// ---------------------------------------------------------------------------
// lpsi_ctrl
// sequencer: steps one point through decision, lane passes and emission
// ---------------------------------------------------------------------------
`include "laser_point_sparkle_inserter_assert.svh"

module lpsi_ctrl
  import lpsi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.sel      = SEL_POS;
    cmd.kind     = EMIT_CUR;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
        if (in_tvalid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        cmd.sel   = SEL_POS;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.st_pos = 1'b1;
        cmd.sel    = SEL_BLEND;
        state_nxt  = ST_DEC;
      end
      ST_DEC: begin
        cmd.st_blend = 1'b1;
        cmd.decide   = 1'b1;
        state_nxt    = sts.sparkle ? ST_FADE : ST_E_CUR;
      end
      ST_FADE: begin
        cmd.sel   = SEL_FADE;
        state_nxt = ST_FST;
      end
      ST_FST: begin
        cmd.st_fade = 1'b1;
        state_nxt   = ST_E_FADE0;
      end
      ST_E_FADE0: begin
        cmd.kind = EMIT_FADE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_E_SPARK;
        end
      end
      ST_E_SPARK: begin
        cmd.kind = EMIT_SPARK;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_E_FADE1;
        end
      end
      ST_E_FADE1: begin
        cmd.kind = EMIT_FADE;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_E_CUR;
        end
      end
      ST_E_CUR: begin
        cmd.kind = EMIT_CUR;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.commit = 1'b1;
          in_tready  = 1'b1;
          cmd.cap    = in_tvalid;
          state_nxt  = in_tvalid ? ST_CALC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `LPSI_ASSERT_NXT(a_acc_calc, in_tvalid && in_tready, state_r == ST_CALC, "transfer did not start calc")
  `LPSI_ASSERT_NOW(a_fade_dec, state_r == ST_FADE, $past(state_r) == ST_DEC && $past(sts.sparkle), "fade pass without sparkle")

endmodule

// ----- design/laser_point_sparkle_inserter.sv -----
// ---------------------------------------------------------------------------
// laser_point_sparkle_inserter
// inserts short three-point sparkles ahead of laser scan points
// ---------------------------------------------------------------------------
// Points enter on the in_ stream (frame start flag on in_tuser) and leave on
// the out_ stream; out_tlast marks the forwarded current point. Registers are
// written through cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the block is idle, as the block itself does not enforce it. The
// next point is taken in the cycle the current point's result is loaded.
// For a point with a sparkle, three shared interpolation lanes make a
// position pass, a blend pass and a fade pass, then four points leave one
// per cycle through the output register while the receiver takes them.
// Reset restores the register defaults and clears the previous point and
// the last sparkle position. When the receiver stalls, the result waits in
// the output register and the sequencer holds until it is taken.
// ---------------------------------------------------------------------------
module laser_point_sparkle_inserter
  import lpsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_x, pos_y, pos_z, color_r, color_g, color_b, repeats, ratio,
  // random_gate, random_mix, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // frame_start
  input  logic [0:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // out_x, out_y, out_z, out_r, out_g, out_b, out_repeats
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lpsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpsi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- test/laser_point_sparkle_inserter_tb.sv -----
// ---------------------------------------------------------------------------
// laser_point_sparkle_inserter_tb
// self-checking stream test of the sparkle inserter: a clocked driver feeds
// scan points from a queue, a clocked monitor predicts the emitted points of
// every transfer and compares each output transfer field by field; settings
// change between phases while idle, with random source and sink stalls
// ---------------------------------------------------------------------------
module laser_point_sparkle_inserter_tb
  import lpsi_pkg::*;
();

  localparam int PHASES        = 8;
  localparam int PHASE_POINTS  = 33;
  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic     fs;
    in_item_t data;
  } scan_point_t;

  typedef struct packed {
    logic      last;
    out_item_t data;
  } emitted_point_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  // pos_x, pos_y, pos_z, color_r, color_g, color_b, repeats, ratio,
  // random_gate, random_mix, zero pad
  logic [IN_W-1:0]  in_tdata = '0;
  // frame_start
  logic [0:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // out_x, out_y, out_z, out_r, out_g, out_b, out_repeats
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  laser_point_sparkle_inserter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // register shadow
  logic        reg_enable;
  logic [16:0] reg_density;
  logic [15:0] reg_red, reg_green, reg_blue;
  logic [16:0] reg_alpha;
  logic        reg_follow;
  logic [15:0] reg_min_dist;

  // previous point and sparkle anchor
  logic [15:0] last_x, last_y, last_z, last_r, last_g, last_b;
  logic [15:0] anchor_x, anchor_y;

  scan_point_t    scan_feed[$];
  emitted_point_t emission_q[$];
  scan_point_t    next_point;

  int points_sent;
  int points_taken;
  int results_seen;
  int sparkles;
  int errors;
  int stall_cycles;
  int send_pct;
  int recv_pct;
  logic in_moved = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] sat_q16(logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [16:0] scale_q16(logic [16:0] a, logic [16:0] b);
    longint unsigned la, lb, p;
    la = a;
    lb = b;
    p = (la * lb + 64'd32768) >> 16;
    return p[16:0];
  endfunction

  // a*(1-w) + b*w, rounded half up, clamped to 16 bits
  function automatic logic [15:0] weigh_q16(logic [15:0] a, logic [15:0] b, logic [16:0] w);
    longint unsigned la, lb, lw, s;
    la = a;
    lb = b;
    lw = w;
    s = (la * (64'd65536 - lw) + lb * lw + 64'd32768) >> 16;
    return (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void push_emission(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                        logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                        logic [7:0] rep, logic last);
    emitted_point_t e;
    e.data.out_x = x;
    e.data.out_y = y;
    e.data.out_z = z;
    e.data.out_r = r;
    e.data.out_g = g;
    e.data.out_b = b;
    e.data.out_repeats = rep;
    e.last = last;
    emission_q.push_back(e);
  endfunction

  function automatic void predict_emission(in_item_t it, logic fs);
    logic [16:0] ratio, eff_d, eff_a;
    logic [15:0] sr, sg, sb, zx, zy, zz, fr, fg, fb;
    logic [15:0] mix;
    longint px, py, ax, ay, dx, dy;
    longint unsigned d2, m2, lm;
    ratio = sat_q16(it.ratio);
    mix = it.random_mix;
    if (fs) begin
      anchor_x = '0;
      anchor_y = '0;
    end
    eff_d = reg_follow ? scale_q16(ratio, sat_q16(reg_density)) : sat_q16(reg_density);
    eff_a = reg_follow ? scale_q16(ratio, sat_q16(reg_alpha)) : sat_q16(reg_alpha);
    if (reg_enable && !fs && ({1'b0, it.random_gate} < eff_d)) begin
      px = $signed(it.pos_x);
      py = $signed(it.pos_y);
      ax = $signed(anchor_x);
      ay = $signed(anchor_y);
      dx = px - ax;
      dy = py - ay;
      d2 = dx * dx + dy * dy;
      lm = reg_min_dist;
      m2 = lm * lm;
      if (d2 > m2) begin
        sr = weigh_q16(last_r, reg_red, eff_a);
        sg = weigh_q16(last_g, reg_green, eff_a);
        sb = weigh_q16(last_b, reg_blue, eff_a);
        zx = weigh_q16(last_x ^ BIAS_MSB, it.pos_x ^ BIAS_MSB, {1'b0, mix}) ^ BIAS_MSB;
        zy = weigh_q16(last_y ^ BIAS_MSB, it.pos_y ^ BIAS_MSB, {1'b0, mix}) ^ BIAS_MSB;
        zz = weigh_q16(last_z ^ BIAS_MSB, it.pos_z ^ BIAS_MSB, {1'b0, mix}) ^ BIAS_MSB;
        fr = weigh_q16(last_r, sr, {1'b0, mix});
        fg = weigh_q16(last_g, sg, {1'b0, mix});
        fb = weigh_q16(last_b, sb, {1'b0, mix});
        push_emission(zx, zy, zz, fr, fg, fb, FADE_REPEATS, 1'b0);
        push_emission(zx, zy, zz, sr, sg, sb, SPARK_REPEATS, 1'b0);
        push_emission(zx, zy, zz, fr, fg, fb, FADE_REPEATS, 1'b0);
        anchor_x = last_x;
        anchor_y = last_y;
        sparkles++;
      end
    end
    push_emission(it.pos_x, it.pos_y, it.pos_z, it.color_r, it.color_g, it.color_b,
                  it.repeats, 1'b1);
    last_x = it.pos_x;
    last_y = it.pos_y;
    last_z = it.pos_z;
    last_r = it.color_r;
    last_g = it.color_g;
    last_b = it.color_b;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_point(logic fs, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                    logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                    logic [7:0] rep, logic [16:0] ratio,
                                    logic [15:0] gate, logic [15:0] mix);
    scan_point_t sp;
    sp.fs = fs;
    sp.data.pad = '0;
    sp.data.pos_x = x;
    sp.data.pos_y = y;
    sp.data.pos_z = z;
    sp.data.color_r = r;
    sp.data.color_g = g;
    sp.data.color_b = b;
    sp.data.repeats = rep;
    sp.data.ratio = ratio;
    sp.data.random_gate = gate;
    sp.data.random_mix = mix;
    scan_feed.push_back(sp);
    points_sent++;
  endfunction

  function automatic logic [16:0] pick_ratio();
    if ($urandom_range(0, 9) == 0) return 17'($urandom_range(65537, 131071));
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic bit stall_now(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE:    reg_enable = val[0];
      CFG_DENSITY:   reg_density = val[16:0];
      CFG_SPK_RED:   reg_red = val[15:0];
      CFG_SPK_GREEN: reg_green = val[15:0];
      CFG_SPK_BLUE:  reg_blue = val[15:0];
      CFG_SPK_ALPHA: reg_alpha = val[16:0];
      CFG_FOLLOW:    reg_follow = val[0];
      CFG_MIN_DIST:  reg_min_dist = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic en, logic [16:0] dens, logic [15:0] r, logic [15:0] g,
                                logic [15:0] b, logic [16:0] alpha, logic follow,
                                logic [15:0] min_dist);
    write_reg(CFG_ENABLE, 17'(en));
    write_reg(CFG_DENSITY, dens);
    write_reg(CFG_SPK_RED, 17'(r));
    write_reg(CFG_SPK_GREEN, 17'(g));
    write_reg(CFG_SPK_BLUE, 17'(b));
    write_reg(CFG_SPK_ALPHA, alpha);
    write_reg(CFG_FOLLOW, 17'(follow));
    write_reg(CFG_MIN_DIST, 17'(min_dist));
  endtask

  task automatic settle();
    while (points_taken != points_sent || emission_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_moved)) begin
      if (scan_feed.size() != 0 && !stall_now(send_pct)) begin
        next_point = scan_feed.pop_front();
        in_tdata <= next_point.data;
        in_tuser <= next_point.fs;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && !stall_now(recv_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    emitted_point_t want;
    out_item_t      got;
    in_moved <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_emission(in_item_t'(in_tdata), in_tuser[0]);
        points_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (emission_q.size() == 0) begin
          $error("output transfer with no point predicted");
          errors++;
        end else begin
          want = emission_q.pop_front();
          got = out_item_t'(out_tdata);
          check_field("out_x", want.data.out_x, got.out_x);
          check_field("out_y", want.data.out_y, got.out_y);
          check_field("out_z", want.data.out_z, got.out_z);
          check_field("out_r", want.data.out_r, got.out_r);
          check_field("out_g", want.data.out_g, got.out_g);
          check_field("out_b", want.data.out_b, got.out_b);
          check_field("out_repeats", want.data.out_repeats, got.out_repeats);
          check_field("last_of_run", want.last, out_tlast);
          results_seen++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int phase, count, frame_len, amp, k;
    int x, y, z;
    logic en;
    logic [16:0] dens, alpha;
    logic [15:0] cr, cg, cb, min_dist;

    points_sent = 0;
    points_taken = 0;
    results_seen = 0;
    sparkles = 0;
    errors = 0;
    stall_cycles = 0;
    send_pct = 0;
    recv_pct = 0;
    reg_enable = 1'b1;
    reg_density = '0;
    reg_red = 16'hFFFF;
    reg_green = 16'hFFFF;
    reg_blue = 16'hFFFF;
    reg_alpha = ONE_Q16;
    reg_follow = 1'b0;
    reg_min_dist = 16'd33;
    last_x = '0; last_y = '0; last_z = '0;
    last_r = '0; last_g = '0; last_b = '0;
    anchor_x = '0; anchor_y = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: density zero never sparkles
    add_point(1'b0, 16'd100, 16'hFF9C, 16'd0, 16'd500, 16'd600, 16'd700, 8'd1,
              17'd65536, 16'd0, 16'd0);
    add_point(1'b0, 16'd4000, 16'd4000, 16'd9, 16'd1, 16'd2, 16'd3, 8'd4,
              17'd65536, 16'd0, 16'hFFFF);
    settle();

    apply_settings(1'b1, ONE_Q16, 16'hFFFF, 16'h0000, 16'h3039, ONE_Q16, 1'b0, 16'd0);
    // frame start blocks the sparkle
    add_point(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0,
              17'd0, 16'd0, 16'd0);
    add_point(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
              17'd0, 16'd0, 16'd0);
    add_point(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 8'd1,
              17'h1FFFF, 16'hFFFF, 16'hFFFF);
    add_point(1'b0, 16'h1234, 16'h1234, 16'h0000, 16'h8000, 16'h4000, 16'h2000, 8'd3,
              17'h10000, 16'h8000, 16'h8000);
    add_point(1'b0, 16'h1234, 16'h1234, 16'h0000, 16'h8000, 16'h4000, 16'h2000, 8'd3,
              17'h10000, 16'h0001, 16'h4000);
    // same spot as the anchor: distance zero is not beyond the minimum
    add_point(1'b0, 16'h1234, 16'h1234, 16'h0000, 16'h8000, 16'h4000, 16'h2000, 8'd3,
              17'h10000, 16'h0000, 16'hC000);
    add_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd7,
              17'h08000, 16'h1111, 16'h2222);
    add_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 8'd8,
              17'h08000, 16'h3333, 16'h8000);
    settle();

    // saturating settings and the largest minimum distance
    apply_settings(1'b1, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 1'b1,
                   16'hFFFF);
    add_point(1'b0, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd9,
              17'h1FFFF, 16'hFFFF, 16'h7FFF);
    add_point(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h5678, 16'h9ABC, 8'd2,
              17'd0, 16'd0, 16'd0);
    add_point(1'b0, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd5,
              17'h08000, 16'd0, 16'h8000);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      en = (phase != 5);
      dens = (phase == 0) ? ONE_Q16 : (phase == 3) ? 17'h1FFFF : (phase == 6) ? 17'd0 :
             17'($urandom_range(16384, 65536));
      cr = (phase == 2) ? 16'hFFFF : (phase == 4) ? 16'h0000 : 16'($urandom);
      cg = (phase == 2) ? 16'hFFFF : (phase == 4) ? 16'h0000 : 16'($urandom);
      cb = (phase == 2) ? 16'hFFFF : (phase == 4) ? 16'h0000 : 16'($urandom);
      alpha = (phase == 3) ? 17'h1FFFF : (phase == 4) ? 17'd0 :
              17'($urandom_range(0, 65536));
      min_dist = (phase == 3) ? 16'hFFFF : (phase == 6) ? 16'd0 :
                 16'($urandom_range(0, 300));
      apply_settings(en, dens, cr, cg, cb, alpha, phase[0], min_dist);
      case (phase % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 86; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 86; end
        default: begin send_pct = 31; recv_pct = 31; end
      endcase
      count = 0;
      while (count < PHASE_POINTS) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise point
          add_point(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                    pick_ratio(), 16'($urandom), 16'($urandom));
          count++;
        end else begin
          // one frame of a scan path, small or large steps
          frame_len = $urandom_range(4, 12);
          amp = $urandom_range(0, 1) ? 128 : 12000;
          x = $urandom;
          y = $urandom;
          z = $urandom;
          for (k = 0; k < frame_len; k++) begin
            add_point(k == 0, x[15:0], y[15:0], z[15:0], 16'($urandom), 16'($urandom),
                      16'($urandom), 8'($urandom), pick_ratio(), 16'($urandom),
                      16'($urandom));
            x += int'($urandom_range(0, 2 * amp)) - amp;
            y += int'($urandom_range(0, 2 * amp)) - amp;
            z += int'($urandom_range(0, 2 * amp)) - amp;
          end
          count += frame_len;
        end
      end
      settle();
    end

    if (emission_q.size() != 0) begin
      $error("%0d predicted points never came out", emission_q.size());
      errors++;
    end
    $display("run covered %0d scan points over %0d setting phases", points_taken, PHASES + 3);
    $display("%0d points emitted, %0d of the inserts were sparkles", results_seen, sparkles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- laser_point_sparkle_inserter.f -----
+incdir+design
design/lpsi_pkg.sv
design/lpsi_lerp.sv
design/lpsi_dp.sv
design/lpsi_ctrl.sv
design/laser_point_sparkle_inserter.sv
test/laser_point_sparkle_inserter_tb.sv
